>>> sv/efws_pkg.sv
// shared types, constants and codes for the earliest-free worker scheduler
package efws_pkg;

   // sizing
   localparam int MAX_WORKERS = 16;
   localparam int WIDX_W      = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int CNT_W       = $clog2(MAX_WORKERS + 1);

   // field widths
   localparam int DUR_W  = 30;
   localparam int TIME_W = 48;
   localparam int ACT_W  = 5;
   localparam int WOUT_W = 4;

   localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(16);

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } seq_state_type;

   // shared unit operations
   typedef enum logic {
      ALU_CMP,
      ALU_ADD
   } alu_op_type;

   // shared unit result
   typedef struct packed {
      logic              less;
      logic [TIME_W-1:0] sum;
   } alu_res_type;

   // sequencer controls toward the datapath
   typedef struct packed {
      logic              req_ready;
      logic [WIDX_W-1:0] rd_addr;
      logic              cmp_en;
      logic              cmp_first;
      logic [WIDX_W-1:0] cmp_idx;
      logic              add_phase;
      logic              finish;
   } seq_ctl_type;

endpackage

>>> sv/efws_req_if.sv
// job item channel: duration and batch flag
interface efws_req_if
   import efws_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [DUR_W-1:0] job_duration;
   logic             new_batch;

   modport source (output valid, output job_duration, output new_batch, input ready);
   modport sink (input valid, input job_duration, input new_batch, output ready);
endinterface

>>> sv/efws_rsp_if.sv
// assignment item channel: chosen worker and start time
interface efws_rsp_if
   import efws_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [WOUT_W-1:0] worker_index;
   logic [TIME_W-1:0] start_time;

   modport source (output valid, output worker_index, output start_time, input ready);
   modport sink (input valid, input worker_index, input start_time, output ready);
endinterface

>>> sv/efws_ram.sv
// generic single-write, single-read ram with registered read data
module efws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/efws_alu.sv
// shared 49-bit adder: less-than compare or saturating add of the duration
module efws_alu
   import efws_pkg::*;
(
   input  alu_op_type        op,
   input  logic [TIME_W-1:0] a,
   input  logic [TIME_W-1:0] b,
   input  logic [DUR_W-1:0]  dur,
   output alu_res_type       res
);
   logic [TIME_W:0] opnd;
   logic [TIME_W:0] total;
   logic            cin;

   // compare runs a - b, add runs a + dur
   always_comb begin
      case (op)
         ALU_CMP: begin
            opnd = ~{1'b0, b};
            cin  = 1'b1;
         end
         ALU_ADD: begin
            opnd = (TIME_W + 1)'(dur);
            cin  = 1'b0;
         end
         default: begin
            opnd = '0;
            cin  = 1'b0;
         end
      endcase
   end

   assign total = {1'b0, a} + opnd + (TIME_W + 1)'(cin);

   // top bit is the borrow on compare and the carry on add
   assign res.less = total[TIME_W];
   assign res.sum  = total[TIME_W] ? '1 : total[TIME_W-1:0];
endmodule

>>> sv/efws_seq.sv
// sequencer: scan counter and state machine driving the shared unit
module efws_seq
   import efws_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [CNT_W-1:0] count,
   input  logic             out_free,
   output seq_ctl_type      ctl
);
   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] cnt_prev;

   assign cnt_prev = cnt_ff - CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (cnt_ff == count) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // scan counter
   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_SCAN) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // outputs
   always_comb begin
      ctl           = '0;
      ctl.rd_addr   = cnt_ff[WIDX_W-1:0];
      ctl.cmp_idx   = cnt_prev[WIDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            ctl.req_ready = 1'b1;
         end
         ST_SCAN: begin
            ctl.cmp_en    = (cnt_ff != '0);
            ctl.cmp_first = (cnt_ff == CNT_W'(1));
         end
         ST_UPDATE: begin
            ctl.add_phase = 1'b1;
            ctl.finish    = out_free;
         end
         default: begin
            ctl.req_ready = 1'b0;
         end
      endcase
   end
endmodule

>>> sv/earliest_free_worker_scheduler.sv
// top level: picks the earliest-free active worker for each job item
// operation: each item is scanned over the active entries of the free-time ram,
//   one entry at a time through one shared compare/add unit, then the chosen entry
//   is updated; a new item is accepted only from idle, after the previous update
// reset: synchronous, active high; all free times read as zero, active_workers is 16
// the result register lets a new item enter while the previous result waits
module earliest_free_worker_scheduler
   import efws_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   efws_req_if.sink         req_ch,
   efws_rsp_if.source       rsp_ch,
   input  logic             csr_write_enable,
   input  logic [ACT_W-1:0] csr_write_data
);
   seq_ctl_type       ctl;
   alu_res_type       alu_res;
   alu_op_type        alu_op;

   logic [ACT_W-1:0]  active_workers_ff;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [DUR_W-1:0]  dur_ff;
   logic [TIME_W-1:0] best_ff, best_in;
   logic [WIDX_W-1:0] best_idx_ff, best_idx_in;
   logic [MAX_WORKERS-1:0] valid_ff, valid_in;
   logic              rd_valid_ff;
   logic [TIME_W-1:0] rd_data;
   logic [TIME_W-1:0] cur_time;
   logic [31:0]       act_ext;
   logic [31:0]       act_eff;
   logic              accept;
   logic              out_free;
   logic              rsp_valid_ff;
   logic [WOUT_W-1:0] rsp_index_ff;
   logic [TIME_W-1:0] rsp_time_ff;

   assign accept   = req_ch.valid && ctl.req_ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_workers_ff <= ACT_RESET;
      end else if (csr_write_enable) begin
         active_workers_ff <= csr_write_data;
      end
   end

   // clamp the active count to 1..MAX_WORKERS
   assign act_ext = 32'(active_workers_ff);
   always_comb begin
      if (act_ext == 32'd0) begin
         act_eff = 32'd1;
      end else if (act_ext > 32'(MAX_WORKERS)) begin
         act_eff = 32'(MAX_WORKERS);
      end else begin
         act_eff = act_ext;
      end
   end

   // item latch
   assign n_in = accept ? CNT_W'(act_eff) : n_ff;

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      if (accept) begin
         dur_ff <= req_ch.job_duration;
      end
   end

   efws_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .count    (n_ff),
      .out_free (out_free),
      .ctl      (ctl)
   );

   // free-time store; unwritten or batch-cleared entries read as zero
   efws_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_WORKERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.finish),
      .wr_addr (best_idx_ff),
      .wr_data (alu_res.sum),
      .rd_addr (ctl.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (accept && req_ch.new_batch) begin
         valid_in = '0;
      end else if (ctl.finish) begin
         valid_in[best_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[ctl.rd_addr];
   end

   assign cur_time = rd_valid_ff ? rd_data : '0;

   // shared unit: compare during the scan, saturating add at update
   assign alu_op = ctl.add_phase ? ALU_ADD : ALU_CMP;

   efws_alu u_alu (
      .op  (alu_op),
      .a   (ctl.add_phase ? best_ff : cur_time),
      .b   (best_ff),
      .dur (dur_ff),
      .res (alu_res)
   );

   // running minimum, strict less keeps the lowest index on ties
   always_comb begin
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (ctl.cmp_en && (ctl.cmp_first || alu_res.less)) begin
         best_in     = cur_time;
         best_idx_in = ctl.cmp_idx;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_index_ff <= WOUT_W'(best_idx_ff);
         rsp_time_ff  <= best_ff;
      end
   end

   assign req_ch.ready        = ctl.req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.worker_index = rsp_index_ff;
   assign rsp_ch.start_time   = rsp_time_ff;

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("ready while an item is in progress");

   // chosen worker lies among the active ones
   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> (32'(best_idx_ff) < 32'(n_ff)))
      else $error("chosen worker outside the active range");

   // a new batch forgets every free time
   a_batch_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.new_batch) |=> (valid_ff == '0))
      else $error("free times not cleared on new batch");

   // a finished item shows up on the result channel
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> rsp_ch.valid)
      else $error("finished item not presented");
endmodule

>>> test/efws_sched_check_pkg.sv
// scoreboard for the earliest-free worker scheduler: free-time predictor and result checks
package efws_sched_check_pkg;
   import efws_pkg::*;

   // one predicted assignment: chosen worker and the job's start time
   typedef struct packed {
      logic [WOUT_W-1:0] worker;
      logic [TIME_W-1:0] start;
   } assignment_type;

   class assignment_scoreboard;
      logic [TIME_W-1:0] free_time [MAX_WORKERS];
      logic [ACT_W-1:0]  active_workers;
      assignment_type    pending_assignments [$];
      int                errors;

      // state right after reset
      function void power_up();
         foreach (free_time[i]) free_time[i] = '0;
         active_workers = ACT_RESET;
         pending_assignments.delete();
         errors = 0;
      endfunction

      function void set_active(input logic [ACT_W-1:0] value);
         active_workers = value;
      endfunction

      function int pending();
         return pending_assignments.size();
      endfunction

      // count a failure, show only the first few
      function void flag_mismatch(input string msg);
         errors++;
         if (errors <= 10) $display("mismatch: %s", msg);
      endfunction

      // accepted job item: pick the earliest-free active worker and advance it
      function void note_job(input logic [DUR_W-1:0] dur, input logic new_batch);
         int unsigned      count;
         int unsigned      best;
         logic [TIME_W:0]  sum;
         assignment_type   item;
         if (new_batch) begin
            foreach (free_time[i]) free_time[i] = '0;
         end
         // zero workers behaves as one, too many is clipped
         count = active_workers;
         if (count < 1) count = 1;
         if (count > MAX_WORKERS) count = MAX_WORKERS;
         best = 0;
         // strict compare keeps the lowest index on ties
         for (int i = 1; i < count; i++) begin
            if (free_time[i] < free_time[best]) best = i;
         end
         item.worker = WOUT_W'(best);
         item.start  = free_time[best];
         sum = free_time[best] + dur;
         // saturate at the top of the time range
         free_time[best] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
         pending_assignments.push_back(item);
      endfunction

      // accepted result item: compare with the oldest prediction
      function void check_assignment(input logic [WOUT_W-1:0] worker,
                                     input logic [TIME_W-1:0] start);
         assignment_type want;
         if (pending_assignments.size() == 0) begin
            flag_mismatch($sformatf("unexpected item worker %0d start %0d", worker, start));
            return;
         end
         want = pending_assignments.pop_front();
         if (worker !== want.worker)
            flag_mismatch($sformatf("worker_index expected %0d actual %0d",
                                    want.worker, worker));
         if (start !== want.start)
            flag_mismatch($sformatf("start_time expected %0d actual %0d",
                                    want.start, start));
      endfunction
   endclass

endpackage

>>> test/earliest_free_worker_scheduler_tb.sv
// testbench top for the earliest-free worker scheduler
module earliest_free_worker_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import efws_pkg::*;
   import efws_sched_check_pkg::*;

   localparam int SETTLE_CYCLES   = 40;
   localparam int RANDOM_ITEMS    = 1750;
   localparam int ONE_WORKER_JOBS = 8;
   localparam int HOLD_CYCLES     = 400;
   localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [ACT_W-1:0] csr_write_data;

   efws_req_if req_bus ();
   efws_rsp_if rsp_bus ();

   assignment_scoreboard scoreboard;

   int jobs_taken;
   int rsp_hold_cycles;
   bit src_gaps;
   bit sink_gaps;

   earliest_free_worker_scheduler uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            scoreboard.note_job(req_bus.job_duration, req_bus.new_batch);
            jobs_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready)
            scoreboard.check_assignment(rsp_bus.worker_index, rsp_bus.start_time);
      end
   end

   // result receiver: long hold-off, random stalls or always ready
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (sink_gaps) begin
            rsp_bus.ready <= ($urandom_range(99) >= 37);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // mixed duration shapes: zero, max, small ties, powers of two, full random
   function automatic logic [DUR_W-1:0] pick_duration();
      case ($urandom_range(9))
         0: return '0;
         1: return DUR_MAX;
         2, 3, 4: return DUR_W'($urandom_range(0, 7));
         5: return DUR_W'(1) << $urandom_range(0, DUR_W - 1);
         default: return DUR_W'($urandom);
      endcase
   endfunction

   // offer one job item and hold it until the handshake
   task automatic offer_job(input logic [DUR_W-1:0] dur, input logic new_batch);
      int taken_before;
      int gap;
      gap = 0;
      while (src_gaps && $urandom_range(99) < 37) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.job_duration <= dur;
      req_bus.new_batch    <= new_batch;
      taken_before = jobs_taken;
      do @(negedge clock); while (jobs_taken == taken_before);
   endtask

   // wait until every predicted item has come back
   task automatic wait_drained();
      while (scoreboard.pending() != 0) @(negedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_active(input logic [ACT_W-1:0] value);
      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      scoreboard.set_active(value);
   endtask

   // random phase: mostly batches that open with the flag, some noise
   task automatic run_phase(input int length, inout int sent);
      int done;
      int batch_len;
      done = 0;
      while (done < length) begin
         if ($urandom_range(99) < 80) begin
            batch_len = $urandom_range(1, 40);
            for (int j = 0; j < batch_len; j++) offer_job(pick_duration(), j == 0);
            done += batch_len;
         end else begin
            offer_job(pick_duration(), $urandom_range(3) == 0);
            done++;
         end
      end
      sent += done;
   endtask

   // main sequence
   initial begin
      int sent;
      int phase;
      int phase_len;
      logic [ACT_W-1:0] setting;

      scoreboard = new;
      scoreboard.power_up();
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.job_duration = '0;
      req_bus.new_batch    = 1'b0;
      csr_write_enable     = 1'b0;
      csr_write_data       = '0;
      jobs_taken           = 0;
      rsp_hold_cycles      = 0;
      src_gaps             = 1'b1;
      sink_gaps            = 1'b1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset count of 16, ties at zero, max duration, batch clear
      offer_job('0, 1'b0);
      offer_job(DUR_MAX, 1'b0);
      offer_job(DUR_W'(7), 1'b0);
      offer_job(DUR_W'(7), 1'b0);
      offer_job(DUR_W'(1), 1'b1);
      offer_job(DUR_W'(3), 1'b0);
      // shrink to two workers, the rest keep their free times
      write_active(ACT_W'(2));
      offer_job(DUR_W'(4), 1'b0);
      offer_job(DUR_W'(4), 1'b0);
      offer_job(DUR_W'(9), 1'b0);
      write_active(ACT_W'(16));
      offer_job(DUR_W'(2), 1'b0);
      offer_job(DUR_W'(2), 1'b0);
      offer_job(DUR_MAX, 1'b0);
      // zero count acts as one worker
      write_active(ACT_W'(0));
      offer_job(DUR_W'(5), 1'b0);
      offer_job(DUR_W'(5), 1'b0);
      offer_job('0, 1'b0);
      // counts above the worker total are clipped
      write_active(ACT_W'(31));
      offer_job(DUR_W'(6), 1'b1);
      offer_job(DUR_W'(6), 1'b0);
      write_active(ACT_W'(17));
      offer_job(DUR_MAX, 1'b0);
      offer_job(DUR_W'(1), 1'b0);

      // single worker: max durations pile up back to back on worker 0
      src_gaps  = 1'b0;
      sink_gaps = 1'b0;
      write_active(ACT_W'(1));
      for (int i = 0; i < ONE_WORKER_JOBS; i++) offer_job(DUR_MAX, i == 0);
      offer_job('0, 1'b0);
      offer_job(DUR_W'(1), 1'b1);

      // random phases over many settings
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(7))
            0: setting = ACT_W'(0);
            1: setting = ACT_W'(1);
            2: setting = ACT_W'(16);
            3: setting = ACT_W'(31);
            4: setting = ACT_W'(2);
            default: setting = ACT_W'($urandom_range(0, 31));
         endcase
         if (phase == 1) setting = ACT_W'(16);
         write_active(setting);
         phase_len = $urandom_range(30, 90);
         if (phase == 1) begin
            // receiver holds off while the sender keeps offering
            src_gaps        = 1'b0;
            sink_gaps       = 1'b0;
            rsp_hold_cycles = HOLD_CYCLES;
         end else if (phase == 2) begin
            // long stretch with no idling
            src_gaps  = 1'b0;
            sink_gaps = 1'b0;
            phase_len = 200;
         end else begin
            src_gaps  = ($urandom_range(3) != 0);
            sink_gaps = ($urandom_range(3) != 0);
         end
         run_phase(phase_len, sent);
         phase++;
      end

      // drain and let any stray item show up
      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> earliest_free_worker_scheduler.f
sv/efws_pkg.sv
sv/efws_req_if.sv
sv/efws_rsp_if.sv
sv/efws_ram.sv
sv/efws_alu.sv
sv/efws_seq.sv
sv/earliest_free_worker_scheduler.sv
test/efws_sched_check_pkg.sv
test/earliest_free_worker_scheduler_tb.sv
